>>> rtl/phdt_pkg.sv
// ----------------------------------------------------------------------------
// phdt_pkg
// Shared field widths and the command/status bundles that pass between the
// perfect/harmonic divisor test controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package phdt_pkg;

  // Fixed field widths of the request and result channels
  localparam int IN_W    = 32;
  localparam int COUNT_W = 11;
  localparam int SUM_W   = 35;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture a new request and reset the scan
    logic div_trial;  // start a trial division n / d
    logic div_mod;    // start the harmonic check (n * count) mod sigma
    logic accum;      // fold the trial result into count and sigma
    logic mul;        // form n * count
    logic publish;    // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sq_le_n;    // current candidate squared is not above n
    logic div_busy;   // divider still iterating
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

`default_nettype wire

>>> rtl/phdt_div.sv
// ----------------------------------------------------------------------------
// phdt_div
// Restoring divider, one quotient bit per cycle. The caller picks the step
// count; a short dividend is loaded left-aligned so fewer steps suffice.
// ----------------------------------------------------------------------------
`default_nettype none

module phdt_div #(
  parameter int DVD_W = 43,
  parameter int DVS_W = 35
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [$clog2(DVD_W+1)-1:0] steps,
  input  wire logic [DVD_W-1:0]           dividend,
  input  wire logic [DVS_W-1:0]           divisor,
  output logic                            busy,
  output logic [DVD_W-1:0]                quotient,
  output logic [DVS_W-1:0]                remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs;

  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W-1:0] rem_next;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    rem_sh   = {rem, quo[DVD_W-1]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= rem_next;
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  assign busy      = cnt != '0;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

>>> rtl/phdt_dp.sv
// ----------------------------------------------------------------------------
// phdt_dp
// Datapath: candidate and square tracking, divisor count and sum
// accumulators, the shared divider, the n * count product and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module phdt_dp #(
  parameter int W = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire phdt_pkg::cmd_t             cmd,
  output phdt_pkg::status_t               status,
  input  wire logic [phdt_pkg::IN_W-1:0]  number,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [phdt_pkg::COUNT_W-1:0]    divisor_count,
  output logic [phdt_pkg::SUM_W-1:0]      proper_divisor_sum,
  output logic                            is_perfect,
  output logic                            is_harmonic
);

  localparam int COUNT_W = phdt_pkg::COUNT_W;
  localparam int SUM_W   = phdt_pkg::SUM_W;
  localparam int DW      = (W + 1) / 2 + 1;   // candidate, up to 2^ceil(W/2)
  localparam int SQW     = 2 * DW;            // candidate squared
  localparam int SW      = W + 3;             // divisor sum
  localparam int PW      = W + COUNT_W;       // n * count
  localparam int CNT_W   = $clog2(PW + 1);

  logic [W-1:0]       n;
  logic [DW-1:0]      d;
  logic [SQW-1:0]     sq;
  logic [COUNT_W-1:0] count;
  logic [SW-1:0]      sigma;
  logic [PW-1:0]      product;

  logic [PW-1:0]      div_dividend;
  logic [SW-1:0]      div_divisor;
  logic [CNT_W-1:0]   div_steps;
  logic               div_busy;
  logic [PW-1:0]      div_quo;
  logic [SW-1:0]      div_rem;

  logic [W-1:0]       partner;
  logic               is_div;
  logic               pair;
  logic [SW-1:0]      proper;

  // Select divider operands for trial or harmonic division
  always_comb begin
    if (cmd.div_mod) begin
      div_dividend = product;
      div_divisor  = sigma;
      div_steps    = CNT_W'(PW);
    end else begin
      div_dividend = {n, {COUNT_W{1'b0}}};
      div_divisor  = SW'(d);
      div_steps    = CNT_W'(W);
    end
  end

  phdt_div #(
    .DVD_W (PW),
    .DVS_W (SW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_trial | cmd.div_mod),
    .steps     (div_steps),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Decode the trial result
  always_comb begin
    partner = div_quo[W-1:0];
    is_div  = div_rem == '0;
    pair    = partner != W'(d);
    proper  = sigma - SW'(n);
  end

  // Scan state and accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n     <= number[W-1:0];
      d     <= DW'(1);
      sq    <= SQW'(1);
      count <= '0;
      sigma <= '0;
    end else if (cmd.accum) begin
      if (is_div) begin
        count <= count + (pair ? COUNT_W'(2) : COUNT_W'(1));
        sigma <= sigma + SW'(d) + (pair ? SW'(partner) : SW'(0));
      end
      d  <= d + 1'b1;
      sq <= sq + SQW'({d, 1'b1});
    end
  end

  // Harmonic numerator
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      product <= PW'(n) * PW'(count);
    end
  end

  // Result register; zero input reports all zeros
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      divisor_count      <= (n != '0) ? count : '0;
      proper_divisor_sum <= (n != '0) ? SUM_W'(proper) : '0;
      is_perfect         <= (n != '0) && (proper == SW'(n));
      is_harmonic        <= (n != '0) && (div_rem == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Status back to the controller
  always_comb begin
    status.sq_le_n  = sq <= SQW'(n);
    status.div_busy = div_busy;
    status.out_free = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

>>> rtl/phdt_ctrl.sv
// ----------------------------------------------------------------------------
// phdt_ctrl
// Controller: takes a request, steps the trial-division scan, then the
// harmonic check, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module phdt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output phdt_pkg::cmd_t         cmd,
  input  wire phdt_pkg::status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TRIAL,
    S_ACCUM,
    S_MUL,
    S_MOD,
    S_HDIV,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.sq_le_n) begin
          cmd.div_trial = 1'b1;
          state_next    = S_TRIAL;
        end else begin
          state_next = S_MUL;
        end
      end
      S_TRIAL: begin
        if (!status.div_busy) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = S_CHECK;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.div_mod = 1'b1;
        state_next  = S_HDIV;
      end
      S_HDIV: begin
        if (!status.div_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = state != S_IDLE;

endmodule

`default_nettype wire

>>> rtl/perfect_harmonic_divisor_test_unit.sv
// Each candidate up to sqrt(n) passes through the CHECK, TRIAL and ACCUM states, with one
// pass of the bit-serial divider in TRIAL; the harmonic multiply and division follow, and
// output stalls add to the total time.
// Requests: one at a time; the next is taken once the result is
// loaded into the output register, while that result may still wait downstream.
// Reset: synchronous, active high; clears the controller and the output valid.
// ----------------------------------------------------------------------------
// perfect_harmonic_divisor_test_unit
// Classifies a positive number: divisor count, proper-divisor sum, perfect
// flag and an exact harmonic-divisor-number flag.
// ----------------------------------------------------------------------------
`default_nettype none

module perfect_harmonic_divisor_test_unit #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [phdt_pkg::IN_W-1:0]     number,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [phdt_pkg::COUNT_W-1:0]       divisor_count,
  output logic [phdt_pkg::SUM_W-1:0]         proper_divisor_sum,
  output logic                               is_perfect,
  output logic                               is_harmonic
);

  phdt_pkg::cmd_t    cmd;
  phdt_pkg::status_t status;

  // Sequencer
  phdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Arithmetic and result register
  phdt_dp #(
    .W (NUMBER_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .number             (number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .divisor_count      (divisor_count),
    .proper_divisor_sum (proper_divisor_sum),
    .is_perfect         (is_perfect),
    .is_harmonic        (is_harmonic)
  );

endmodule

`default_nettype wire
